### src/osmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object stream decoder package
// Shared types, codes and decode functions of the object stream decoder.
// ----------------------------------------------------------------------------
package osmd_pkg;

  typedef enum logic [2:0] {
    KIND_TEXT_HDR  = 3'd0,
    KIND_DATA_HDR  = 3'd1,
    KIND_DATA_BYTE = 3'd2,
    KIND_INSN      = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_MAGIC   = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_SECTION = 3'd3,
    ERR_DECODE  = 3'd4
  } error_e;

  localparam logic [7:0]  MagicByte0    = 8'd76;
  localparam logic [7:0]  MagicByte1    = 8'd97;
  localparam logic [7:0]  MagicByte2    = 8'd88;
  localparam logic [7:0]  MagicByte3    = 8'd0;
  localparam logic [15:0] FileVersion   = 16'd5;
  localparam logic [7:0]  SectText      = 8'd7;
  localparam logic [7:0]  SectData      = 8'd8;

  localparam logic [5:0] MN_ADD       = 6'd0;
  localparam logic [5:0] MN_ADDU      = 6'd1;
  localparam logic [5:0] MN_AND       = 6'd2;
  localparam logic [5:0] MN_NOR       = 6'd3;
  localparam logic [5:0] MN_OR        = 6'd4;
  localparam logic [5:0] MN_SLT       = 6'd5;
  localparam logic [5:0] MN_SLTU      = 6'd6;
  localparam logic [5:0] MN_SLL       = 6'd7;
  localparam logic [5:0] MN_SRA       = 6'd8;
  localparam logic [5:0] MN_SRL       = 6'd9;
  localparam logic [5:0] MN_SUB       = 6'd10;
  localparam logic [5:0] MN_SUBU      = 6'd11;
  localparam logic [5:0] MN_XOR       = 6'd12;
  localparam logic [5:0] MN_JR        = 6'd13;
  localparam logic [5:0] MN_SYSCALL   = 6'd14;
  localparam logic [5:0] MN_J         = 6'd15;
  localparam logic [5:0] MN_JAL       = 6'd16;
  localparam logic [5:0] MN_SLTI      = 6'd17;
  localparam logic [5:0] MN_SLTIU     = 6'd18;
  localparam logic [5:0] MN_BEQ       = 6'd19;
  localparam logic [5:0] MN_BNE       = 6'd20;
  localparam logic [5:0] MN_ORI       = 6'd21;
  localparam logic [5:0] MN_ADDI      = 6'd22;
  localparam logic [5:0] MN_ADDIU     = 6'd23;
  localparam logic [5:0] MN_ANDI      = 6'd24;
  localparam logic [5:0] MN_LUI       = 6'd25;
  localparam logic [5:0] MN_LW        = 6'd26;
  localparam logic [5:0] MN_LBU       = 6'd27;
  localparam logic [5:0] MN_LHU       = 6'd28;
  localparam logic [5:0] MN_SB        = 6'd29;
  localparam logic [5:0] MN_SH        = 6'd30;
  localparam logic [5:0] MN_SW        = 6'd31;
  localparam logic [5:0] MN_UNKNOWN_R = 6'd32;
  localparam logic [5:0] MN_NONE      = 6'd0;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // Work passed from the parser to the decoder. The payload holds the section
  // address, the data byte, the instruction word or the error code.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] payload;
    logic [31:0] pc;
    logic        last;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  mnemonic;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
    logic [31:0] address;
    logic [7:0]  data_value;
    error_e      error_code;
    logic        stream_end;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = MagicByte0;
      2'd1: b = MagicByte1;
      2'd2: b = MagicByte2;
      default: b = MagicByte3;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] r_code(input logic [5:0] fn);
    logic [5:0] c;
    unique case (fn)
      FN_ADD:     c = MN_ADD;
      FN_ADDU:    c = MN_ADDU;
      FN_AND:     c = MN_AND;
      FN_NOR:     c = MN_NOR;
      FN_OR:      c = MN_OR;
      FN_SLT:     c = MN_SLT;
      FN_SLTU:    c = MN_SLTU;
      FN_SLL:     c = MN_SLL;
      FN_SRA:     c = MN_SRA;
      FN_SRL:     c = MN_SRL;
      FN_SUB:     c = MN_SUB;
      FN_SUBU:    c = MN_SUBU;
      FN_XOR:     c = MN_XOR;
      FN_JR:      c = MN_JR;
      FN_SYSCALL: c = MN_SYSCALL;
      default:    c = MN_UNKNOWN_R;
    endcase
    return c;
  endfunction

  // Returns MN_NONE for an opcode that is not a known I-type opcode.
  function automatic logic [5:0] i_code(input logic [5:0] op);
    logic [5:0] c;
    unique case (op)
      OP_SLTI:  c = MN_SLTI;
      OP_SLTIU: c = MN_SLTIU;
      OP_BEQ:   c = MN_BEQ;
      OP_BNE:   c = MN_BNE;
      OP_ORI:   c = MN_ORI;
      OP_ADDI:  c = MN_ADDI;
      OP_ADDIU: c = MN_ADDIU;
      OP_ANDI:  c = MN_ANDI;
      OP_LUI:   c = MN_LUI;
      OP_LW:    c = MN_LW;
      OP_LBU:   c = MN_LBU;
      OP_LHU:   c = MN_LHU;
      OP_SB:    c = MN_SB;
      OP_SH:    c = MN_SH;
      OP_SW:    c = MN_SW;
      default:  c = MN_NONE;
    endcase
    return c;
  endfunction

endpackage

### src/osmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object stream parser
// Walks the file header and the section headers one byte at a time and
// hands headers, data bytes, whole text words and header errors onward.
// ----------------------------------------------------------------------------
module osmd_front
  import osmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       ent_valid_o,
  output entry_t     ent_o
);

  typedef enum logic [8:0] {
    PH_MAGIC   = 9'b000000001,
    PH_VERSION = 9'b000000010,
    PH_COUNT   = 9'b000000100,
    PH_TYPE    = 9'b000001000,
    PH_ADDR    = 9'b000010000,
    PH_SIZE    = 9'b000100000,
    PH_TEXT    = 9'b001000000,
    PH_DATA    = 9'b010000000,
    PH_DONE    = 9'b100000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  seen_q, seen_d;
  logic        is_text_q, is_text_d;
  logic [31:0] base_q, base_d;
  logic [31:0] length_q, length_d;
  logic [31:0] count_q, count_d;
  logic [23:0] asm_q, asm_d;
  logic [31:0] pc_q, pc_d;

  logic [7:0]  seen_inc;
  logic        sect_last;
  logic [31:0] full_length;
  logic [31:0] full_word;
  logic [31:0] pc_inc;
  logic [31:0] count_inc1;
  logic [32:0] count_inc4;

  assign seen_inc    = seen_q + 8'd1;
  assign sect_last   = (seen_inc >= total_q);
  assign full_length = {byte_i, length_q[23:0]};
  assign full_word   = {byte_i, asm_q};
  assign pc_inc      = pc_q + 32'd4;
  assign count_inc1  = count_q + 32'd1;
  assign count_inc4  = {1'b0, count_q} + 33'd4;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    total_d     = total_q;
    seen_d      = seen_q;
    is_text_d   = is_text_q;
    base_d      = base_q;
    length_d    = length_q;
    count_d     = count_q;
    asm_d       = asm_q;
    pc_d        = pc_q;
    ent_valid_o = 1'b0;
    ent_o.kind    = KIND_ERROR;
    ent_o.payload = '0;
    ent_o.pc      = pc_inc;
    ent_o.last    = 1'b0;

    if (accept_i) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (byte_i != magic_byte(idx_q)) begin
            ent_valid_o   = 1'b1;
            ent_o.payload = {29'd0, ERR_MAGIC};
            ent_o.last    = 1'b1;
            phase_d       = PH_DONE;
          end else if (idx_q == 2'd3) begin
            idx_d   = 2'd0;
            phase_d = PH_VERSION;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        PH_VERSION: begin
          if (idx_q == 2'd0) begin
            asm_d[7:0] = byte_i;
            idx_d      = 2'd1;
          end else if ({byte_i, asm_q[7:0]} != FileVersion) begin
            ent_valid_o   = 1'b1;
            ent_o.payload = {29'd0, ERR_VERSION};
            ent_o.last    = 1'b1;
            phase_d       = PH_DONE;
          end else begin
            idx_d   = 2'd0;
            phase_d = PH_COUNT;
          end
        end
        PH_COUNT: begin
          total_d = byte_i;
          seen_d  = 8'd0;
          phase_d = (byte_i == 8'd0) ? PH_DONE : PH_TYPE;
        end
        PH_TYPE: begin
          if (byte_i == SectText || byte_i == SectData) begin
            is_text_d = (byte_i == SectText);
            idx_d     = 2'd0;
            phase_d   = PH_ADDR;
          end else begin
            ent_valid_o   = 1'b1;
            ent_o.payload = {29'd0, ERR_SECTION};
            ent_o.last    = 1'b1;
            phase_d       = PH_DONE;
          end
        end
        PH_ADDR: begin
          base_d[idx_q*8 +: 8] = byte_i;
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            phase_d = PH_SIZE;
          end
        end
        PH_SIZE: begin
          length_d[idx_q*8 +: 8] = byte_i;
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            ent_valid_o   = 1'b1;
            ent_o.kind    = is_text_q ? KIND_TEXT_HDR : KIND_DATA_HDR;
            ent_o.payload = base_q;
            count_d       = 32'd0;
            pc_d          = base_q;
            if (full_length == 32'd0) begin
              ent_o.last = sect_last;
              seen_d     = seen_inc;
              phase_d    = sect_last ? PH_DONE : PH_TYPE;
            end else begin
              phase_d = is_text_q ? PH_TEXT : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          ent_valid_o   = 1'b1;
          ent_o.kind    = KIND_DATA_BYTE;
          ent_o.payload = {24'd0, byte_i};
          if (count_inc1 >= length_q) begin
            ent_o.last = sect_last;
            seen_d     = seen_inc;
            count_d    = 32'd0;
            idx_d      = 2'd0;
            phase_d    = sect_last ? PH_DONE : PH_TYPE;
          end else begin
            count_d = count_inc1;
          end
        end
        PH_TEXT: begin
          idx_d = idx_q + 2'd1;
          if (idx_q != 2'd3) begin
            asm_d[idx_q*8 +: 8] = byte_i;
          end else begin
            pc_d          = pc_inc;
            ent_valid_o   = 1'b1;
            ent_o.kind    = KIND_INSN;
            ent_o.payload = full_word;
            if (count_inc4 >= {1'b0, length_q}) begin
              ent_o.last = sect_last;
              seen_d     = seen_inc;
              count_d    = 32'd0;
              phase_d    = sect_last ? PH_DONE : PH_TYPE;
            end else begin
              count_d = count_inc4[31:0];
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      idx_q     <= 2'd0;
      total_q   <= 8'd0;
      seen_q    <= 8'd0;
      is_text_q <= 1'b0;
      base_q    <= 32'd0;
      length_q  <= 32'd0;
      count_q   <= 32'd0;
      asm_q     <= 24'd0;
      pc_q      <= 32'd0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      total_q   <= total_d;
      seen_q    <= seen_d;
      is_text_q <= is_text_d;
      base_q    <= base_d;
      length_q  <= length_d;
      count_q   <= count_d;
      asm_q     <= asm_d;
      pc_q      <= pc_d;
    end
  end

endmodule

### src/osmd_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser to decoder queue
// Two-entry queue that lets the parser and the decoder stall on their own.
// ----------------------------------------------------------------------------
module osmd_link
  import osmd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t ent_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t ent_o
);

  logic [1:0] count_q, count_d;
  entry_t     slot0_q, slot0_d;
  entry_t     slot1_q, slot1_d;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign ent_o   = slot0_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    priority if (do_push && do_pop) begin
      slot0_d = ent_i;
    end else if (do_push) begin
      if (count_q == 2'd0) begin
        slot0_d = ent_i;
      end else begin
        slot1_d = ent_i;
      end
      count_d = count_q + 2'd1;
    end else if (do_pop) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

### src/osmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction decoder and result queue
// Turns parser work into result items, decodes text words, and holds the
// results in a two-entry queue for the consumer.
// ----------------------------------------------------------------------------
module osmd_back
  import osmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    link_empty_i,
  input  entry_t  ent_i,
  output logic    link_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t res_o
);

  logic        halted_q, halted_d;
  logic [1:0]  count_q, count_d;
  result_t     slot0_q, slot0_d;
  result_t     slot1_q, slot1_d;

  result_t     res;
  logic        dec_ok;
  logic [31:0] w;
  logic [5:0]  op;
  logic [5:0]  rc;
  logic [5:0]  ic;
  logic [31:0] br_off;
  logic        out_full;
  logic        do_push;
  logic        do_pop;

  assign w      = ent_i.payload;
  assign op     = w[31:26];
  assign rc     = r_code(w[5:0]);
  assign ic     = i_code(op);
  assign br_off = {{14{w[15]}}, w[15:0], 2'b00};

  always_comb begin
    res        = '0;
    res.kind   = ent_i.kind;
    res.error_code = ERR_NONE;
    res.stream_end = ent_i.last;
    dec_ok     = 1'b1;
    unique case (ent_i.kind)
      KIND_TEXT_HDR, KIND_DATA_HDR: begin
        res.address = ent_i.payload;
      end
      KIND_DATA_BYTE: begin
        res.data_value = ent_i.payload[7:0];
      end
      KIND_ERROR: begin
        res.error_code = error_e'(ent_i.payload[2:0]);
        res.stream_end = 1'b1;
      end
      KIND_INSN: begin
        if (op == OP_RTYPE) begin
          dec_ok = !((rc == MN_SYSCALL) && (w[31:6] != 26'd0));
          res.mnemonic = rc;
          res.src_reg  = w[25:21];
          res.tgt_reg  = w[20:16];
          res.dst_reg  = w[15:11];
          if (rc == MN_SLL || rc == MN_SRA || rc == MN_SRL) begin
            res.shift_amount = w[10:6];
          end
        end else if (op == OP_J || op == OP_JAL) begin
          res.mnemonic = (op == OP_J) ? MN_J : MN_JAL;
          res.address  = {w[29:0], 2'b00} & 32'h0fff_fffc;
        end else begin
          dec_ok        = (ic != MN_NONE);
          res.mnemonic  = ic;
          res.src_reg   = w[25:21];
          res.tgt_reg   = w[20:16];
          res.immediate = w[15:0];
          if (ic == MN_BEQ || ic == MN_BNE) begin
            res.address = ent_i.pc + br_off;
          end
        end
        if (!dec_ok) begin
          res            = '0;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_DECODE;
          res.stream_end = 1'b1;
        end
      end
      default: begin
        res.kind = KIND_ERROR;
      end
    endcase
  end

  assign out_full   = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign res_o      = slot0_q;
  assign do_pop     = pop_i && !empty_o;
  assign link_pop_o = !link_empty_i && (halted_q || !out_full);
  assign do_push    = link_pop_o && !halted_q;

  always_comb begin
    halted_d = halted_q;
    count_d  = count_q;
    slot0_d  = slot0_q;
    slot1_d  = slot1_q;
    if (do_push && !dec_ok) begin
      halted_d = 1'b1;
    end
    priority if (do_push && do_pop) begin
      if (count_q == 2'd1) begin
        slot0_d = res;
      end else begin
        slot0_d = slot1_q;
        slot1_d = res;
      end
    end else if (do_push) begin
      if (count_q == 2'd0) begin
        slot0_d = res;
      end else begin
        slot1_d = res;
      end
      count_d = count_q + 2'd1;
    end else if (do_pop) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      halted_q <= halted_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

### src/object_stream_mips_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object stream MIPS decoder
// Parses an object file byte stream and emits section headers, data bytes
// and decoded MIPS32 instructions, and an error result where the stream is broken.
//
//   Channel   Handshake          Fields
//   input     push / full        in_byte_i
//   result    empty / pop        kind_o ... stream_end_o
//
// One byte is taken per cycle, back to back while the result side keeps up.
// A byte accepted at an edge enters the link queue at that same edge; its result
// then moves into the result queue once it has room, and can be popped from there.
// Reset clears the parser state and both queues at once.
// A stalled result side fills the result queue, then the link queue, and
// then raises full.
// ----------------------------------------------------------------------------
module object_stream_mips_decoder_unit
  import osmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [5:0]  mnemonic_o,
  output logic [4:0]  src_reg_o,
  output logic [4:0]  tgt_reg_o,
  output logic [4:0]  dst_reg_o,
  output logic [4:0]  shift_amount_o,
  output logic [15:0] immediate_o,
  output logic [31:0] address_o,
  output logic [7:0]  data_value_o,
  output logic [2:0]  error_code_o,
  output logic        stream_end_o
);

  logic    accept;
  logic    ent_valid;
  entry_t  ent_new;
  entry_t  ent_head;
  logic    link_full;
  logic    link_empty;
  logic    link_pop;
  result_t res;

  assign full   = link_full;
  assign accept = push && !link_full;

  osmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (in_byte_i),
    .ent_valid_o (ent_valid),
    .ent_o       (ent_new)
  );

  osmd_link u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ent_valid),
    .ent_i   (ent_new),
    .full_o  (link_full),
    .pop_i   (link_pop),
    .empty_o (link_empty),
    .ent_o   (ent_head)
  );

  osmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .link_empty_i (link_empty),
    .ent_i        (ent_head),
    .link_pop_o   (link_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .res_o        (res)
  );

  assign kind_o         = res.kind;
  assign mnemonic_o     = res.mnemonic;
  assign src_reg_o      = res.src_reg;
  assign tgt_reg_o      = res.tgt_reg;
  assign dst_reg_o      = res.dst_reg;
  assign shift_amount_o = res.shift_amount;
  assign immediate_o    = res.immediate;
  assign address_o      = res.address;
  assign data_value_o   = res.data_value;
  assign error_code_o   = res.error_code;
  assign stream_end_o   = res.stream_end;

endmodule

### verif/tb_object_stream_mips_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object stream MIPS decoder testbench
// Feeds one object file through the decoder with random gaps on the input
// and random stalls on the result side. The file holds one of each
// instruction, extreme addresses, empty and odd-sized sections, and many
// random sections. Each accepted byte drives a model of the parser and
// decoder in the scoreboard. Each popped result is checked field by field
// against the oldest predicted result. The seed picks how the file ends:
// a broken header, a normal end, a bad section type or a fatal instruction.
// ----------------------------------------------------------------------------
module tb_object_stream_mips_decoder_unit;
  import osmd_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam int PhaseBytes  = 80;
  localparam int IdlePct     = 63;
  localparam int BothPct     = 25;
  localparam int MaxPrinted  = 100;
  localparam int FileBytes   = 650;

  localparam int HdrBadMagic   = 0;
  localparam int HdrBadVersion = 1;
  localparam int HdrNoSections = 2;

  localparam int EndNormal     = 0;
  localparam int EndBadType    = 1;
  localparam int EndBadOpcode  = 2;
  localparam int EndBadSyscall = 3;

  localparam logic [5:0] FnUnused = 6'h3f;

  typedef enum logic [8:0] {
    ST_MAGIC   = 9'b000000001,
    ST_VERSION = 9'b000000010,
    ST_COUNT   = 9'b000000100,
    ST_TYPE    = 9'b000001000,
    ST_ADDR    = 9'b000010000,
    ST_SIZE    = 9'b000100000,
    ST_TEXT    = 9'b001000000,
    ST_DATA    = 9'b010000000,
    ST_DONE    = 9'b100000000
  } parse_state_e;

  class decode_scoreboard;
    result_t      predicted_results[$];
    int unsigned  mismatches;
    int unsigned  results_seen;
    parse_state_e phase;
    logic [1:0]   byte_idx;
    logic [7:0]   sect_total;
    logic [7:0]   sect_done;
    logic         is_text;
    logic         stopped;
    logic [31:0]  sect_base;
    logic [31:0]  sect_size;
    logic [31:0]  consumed;
    logic [31:0]  word_buf;
    logic [31:0]  pc;

    function new();
      phase        = ST_MAGIC;
      byte_idx     = '0;
      sect_total   = '0;
      sect_done    = '0;
      is_text      = 1'b0;
      stopped      = 1'b0;
      sect_base    = '0;
      sect_size    = '0;
      consumed     = '0;
      word_buf     = '0;
      pc           = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function logic [7:0] magic_at(logic [1:0] i);
      case (i)
        2'd0: return MagicByte0;
        2'd1: return MagicByte1;
        2'd2: return MagicByte2;
        default: return MagicByte3;
      endcase
    endfunction

    function logic [5:0] fn_mnemonic(logic [5:0] fn);
      case (fn)
        FN_ADD:     return MN_ADD;
        FN_ADDU:    return MN_ADDU;
        FN_AND:     return MN_AND;
        FN_NOR:     return MN_NOR;
        FN_OR:      return MN_OR;
        FN_SLT:     return MN_SLT;
        FN_SLTU:    return MN_SLTU;
        FN_SLL:     return MN_SLL;
        FN_SRA:     return MN_SRA;
        FN_SRL:     return MN_SRL;
        FN_SUB:     return MN_SUB;
        FN_SUBU:    return MN_SUBU;
        FN_XOR:     return MN_XOR;
        FN_JR:      return MN_JR;
        FN_SYSCALL: return MN_SYSCALL;
        default:    return MN_UNKNOWN_R;
      endcase
    endfunction

    function logic [5:0] op_mnemonic(logic [5:0] op);
      case (op)
        OP_SLTI:  return MN_SLTI;
        OP_SLTIU: return MN_SLTIU;
        OP_BEQ:   return MN_BEQ;
        OP_BNE:   return MN_BNE;
        OP_ORI:   return MN_ORI;
        OP_ADDI:  return MN_ADDI;
        OP_ADDIU: return MN_ADDIU;
        OP_ANDI:  return MN_ANDI;
        OP_LUI:   return MN_LUI;
        OP_LW:    return MN_LW;
        OP_LBU:   return MN_LBU;
        OP_LHU:   return MN_LHU;
        OP_SB:    return MN_SB;
        OP_SH:    return MN_SH;
        OP_SW:    return MN_SW;
        default:  return MN_NONE;
      endcase
    endfunction

    function result_t halt_with(error_e code);
      result_t r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      r.stream_end = 1'b1;
      stopped      = 1'b1;
      phase        = ST_DONE;
      return r;
    endfunction

    function logic close_section();
      sect_done = sect_done + 8'd1;
      consumed  = '0;
      byte_idx  = '0;
      if (sect_done >= sect_total) begin
        stopped = 1'b1;
        phase   = ST_DONE;
        return 1'b1;
      end
      phase = ST_TYPE;
      return 1'b0;
    endfunction

    function bit decode_word(logic [31:0] w, output result_t r);
      logic [5:0]  m;
      logic [31:0] offset;
      r      = '0;
      r.kind = KIND_INSN;
      if (w[31:26] == OP_RTYPE) begin
        m = fn_mnemonic(w[5:0]);
        if (m == MN_SYSCALL && w[31:6] != '0) return 1'b0;
        r.mnemonic = m;
        r.src_reg  = w[25:21];
        r.tgt_reg  = w[20:16];
        r.dst_reg  = w[15:11];
        if (m == MN_SLL || m == MN_SRA || m == MN_SRL) r.shift_amount = w[10:6];
      end else if (w[31:26] == OP_J || w[31:26] == OP_JAL) begin
        r.mnemonic = (w[31:26] == OP_J) ? MN_J : MN_JAL;
        r.address  = {w[25:0], 2'b00};
      end else begin
        m = op_mnemonic(w[31:26]);
        if (m == MN_NONE) return 1'b0;
        r.mnemonic  = m;
        r.src_reg   = w[25:21];
        r.tgt_reg   = w[20:16];
        r.immediate = w[15:0];
        if (m == MN_BEQ || m == MN_BNE) begin
          offset    = {{14{w[15]}}, w[15:0], 2'b00};
          r.address = pc + offset;
        end
      end
      return 1'b1;
    endfunction

    function void absorb_byte(logic [7:0] b);
      result_t r;
      bit      emit;
      if (stopped) return;
      r    = '0;
      emit = 1'b0;
      case (phase)
        ST_MAGIC: begin
          if (b != magic_at(byte_idx)) begin
            r    = halt_with(ERR_MAGIC);
            emit = 1'b1;
          end else if (byte_idx == 2'd3) begin
            byte_idx = '0;
            phase    = ST_VERSION;
          end else begin
            byte_idx = byte_idx + 2'd1;
          end
        end
        ST_VERSION: begin
          if (byte_idx == 2'd0) begin
            word_buf = {24'd0, b};
            byte_idx = 2'd1;
          end else if ({b, word_buf[7:0]} != FileVersion) begin
            r    = halt_with(ERR_VERSION);
            emit = 1'b1;
          end else begin
            byte_idx = '0;
            phase    = ST_COUNT;
          end
        end
        ST_COUNT: begin
          sect_total = b;
          sect_done  = '0;
          if (b == 8'd0) begin
            stopped = 1'b1;
            phase   = ST_DONE;
          end else begin
            phase = ST_TYPE;
          end
        end
        ST_TYPE: begin
          if (b == SectText || b == SectData) begin
            is_text   = (b == SectText);
            sect_base = '0;
            byte_idx  = '0;
            phase     = ST_ADDR;
          end else begin
            r    = halt_with(ERR_SECTION);
            emit = 1'b1;
          end
        end
        ST_ADDR: begin
          sect_base[8*byte_idx +: 8] = b;
          if (byte_idx == 2'd3) begin
            byte_idx  = '0;
            sect_size = '0;
            phase     = ST_SIZE;
          end else begin
            byte_idx = byte_idx + 2'd1;
          end
        end
        ST_SIZE: begin
          sect_size[8*byte_idx +: 8] = b;
          if (byte_idx != 2'd3) begin
            byte_idx = byte_idx + 2'd1;
          end else begin
            byte_idx  = '0;
            consumed  = '0;
            pc        = sect_base;
            r.kind    = is_text ? KIND_TEXT_HDR : KIND_DATA_HDR;
            r.address = sect_base;
            if (sect_size == '0) r.stream_end = close_section();
            else phase = is_text ? ST_TEXT : ST_DATA;
            emit = 1'b1;
          end
        end
        ST_DATA: begin
          r.kind       = KIND_DATA_BYTE;
          r.data_value = b;
          consumed     = consumed + 32'd1;
          if (consumed >= sect_size) r.stream_end = close_section();
          emit = 1'b1;
        end
        ST_TEXT: begin
          if (byte_idx == 2'd0) word_buf = {24'd0, b};
          else word_buf[8*byte_idx +: 8] = b;
          if (byte_idx != 2'd3) begin
            byte_idx = byte_idx + 2'd1;
          end else begin
            byte_idx = '0;
            pc       = pc + 32'd4;
            if (!decode_word(word_buf, r)) r = halt_with(ERR_DECODE);
            else if ({1'b0, consumed} + 33'd4 >= {1'b0, sect_size})
              r.stream_end = close_section();
            else consumed = consumed + 32'd4;
            emit = 1'b1;
          end
        end
        default: begin
          stopped = 1'b1;
          phase   = ST_DONE;
        end
      endcase
      if (emit) predicted_results.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("%0t mismatch: %s", $time, msg);
    endtask

    function string field_diff(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) return $sformatf(" %s=%0h/%0h", name, got, want);
      return "";
    endfunction

    task check_result(result_t got);
      result_t want;
      string   diffs;
      results_seen++;
      if (predicted_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want  = predicted_results.pop_front();
      diffs = {field_diff("kind", 32'(got.kind), 32'(want.kind)),
               field_diff("mnemonic", 32'(got.mnemonic), 32'(want.mnemonic)),
               field_diff("src_reg", 32'(got.src_reg), 32'(want.src_reg)),
               field_diff("tgt_reg", 32'(got.tgt_reg), 32'(want.tgt_reg)),
               field_diff("dst_reg", 32'(got.dst_reg), 32'(want.dst_reg)),
               field_diff("shift_amount", 32'(got.shift_amount),
                          32'(want.shift_amount)),
               field_diff("immediate", 32'(got.immediate), 32'(want.immediate)),
               field_diff("address", got.address, want.address),
               field_diff("data_value", 32'(got.data_value), 32'(want.data_value)),
               field_diff("error_code", 32'(got.error_code), 32'(want.error_code)),
               field_diff("stream_end", 32'(got.stream_end), 32'(want.stream_end))};
      if (diffs != "") report($sformatf("result %0d (got/expected):%s", results_seen, diffs));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  in_byte_i;
  logic        empty;
  logic        pop;
  logic [2:0]  kind_o;
  logic [5:0]  mnemonic_o;
  logic [4:0]  src_reg_o;
  logic [4:0]  tgt_reg_o;
  logic [4:0]  dst_reg_o;
  logic [4:0]  shift_amount_o;
  logic [15:0] immediate_o;
  logic [31:0] address_o;
  logic [7:0]  data_value_o;
  logic [2:0]  error_code_o;
  logic        stream_end_o;

  decode_scoreboard sb;
  int               gap_pct;
  int               stall_pct;
  int               idle_cycles = 0;
  logic [7:0]       file_bytes[$];
  logic [5:0]       r_funct_set[15];
  logic [5:0]       i_opcode_set[15];

  object_stream_mips_decoder_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .mnemonic_o     (mnemonic_o),
    .src_reg_o      (src_reg_o),
    .tgt_reg_o      (tgt_reg_o),
    .dst_reg_o      (dst_reg_o),
    .shift_amount_o (shift_amount_o),
    .immediate_o    (immediate_o),
    .address_o      (address_o),
    .data_value_o   (data_value_o),
    .error_code_o   (error_code_o),
    .stream_end_o   (stream_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic void put_u32(logic [31:0] v);
    for (int k = 0; k < 4; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_header(logic [7:0] sect_type, logic [31:0] addr,
                                     logic [31:0] size);
    file_bytes.push_back(sect_type);
    put_u32(addr);
    put_u32(size);
  endfunction

  function automatic logic [31:0] random_word();
    int          sel;
    logic [5:0]  fn;
    logic [31:0] rnd;
    sel = $urandom_range(0, 19);
    rnd = $urandom;
    if (sel < 8) begin
      fn = r_funct_set[$urandom_range(0, 14)];
      if (fn == FN_SYSCALL) return {26'd0, FN_SYSCALL};
      return {OP_RTYPE, rnd[19:0], fn};
    end
    if (sel == 8) begin
      do fn = 6'($urandom_range(0, 63)); while (sb.fn_mnemonic(fn) != MN_UNKNOWN_R);
      return {OP_RTYPE, rnd[19:0], fn};
    end
    if (sel < 11) return {(sel == 9) ? OP_J : OP_JAL, rnd[25:0]};
    return {i_opcode_set[$urandom_range(0, 14)], rnd[25:0]};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (full);
    sb.absorb_byte(b);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        sb.check_result({kind_o, mnemonic_o, src_reg_o, tgt_reg_o, dst_reg_o,
                         shift_amount_o, immediate_o, address_o, data_value_o,
                         error_code_o, stream_end_o});
      end
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          header_mode;
    int          end_mode;
    int          sect_count;
    int          count_pos;
    int          bad_at;
    logic [7:0]  b;
    logic [5:0]  op;
    logic [31:0] w;
    logic [31:0] size;
    logic [31:0] words[$];

    sb = new();
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    pop       <= 1'b0;
    in_byte_i <= 8'd0;
    gap_pct   = 0;
    stall_pct = 0;
    r_funct_set = '{FN_ADD, FN_ADDU, FN_AND, FN_NOR, FN_OR, FN_SLT, FN_SLTU, FN_SLL,
                    FN_SRA, FN_SRL, FN_SUB, FN_SUBU, FN_XOR, FN_JR, FN_SYSCALL};
    i_opcode_set = '{OP_SLTI, OP_SLTIU, OP_BEQ, OP_BNE, OP_ORI, OP_ADDI, OP_ADDIU,
                     OP_ANDI, OP_LUI, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW};

    // A broken header ends the file at once, so only a few seeds take that path.
    header_mode = $urandom_range(0, 19);
    if (header_mode == HdrBadMagic) begin
      bad_at = $urandom_range(0, 3);
      for (int k = 0; k < bad_at; k++) file_bytes.push_back(sb.magic_at(2'(k)));
      b = 8'($urandom);
      if (b == sb.magic_at(2'(bad_at))) b = ~b;
      file_bytes.push_back(b);
    end else begin
      for (int k = 0; k < 4; k++) file_bytes.push_back(sb.magic_at(2'(k)));
      if (header_mode == HdrBadVersion) begin
        w = $urandom;
        if ($urandom_range(0, 1)) w[7:0] = FileVersion[7:0];
        if (w[15:0] == FileVersion) w[15:8] = ~w[15:8];
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
      end else begin
        file_bytes.push_back(FileVersion[7:0]);
        file_bytes.push_back(FileVersion[15:8]);
        count_pos = file_bytes.size();
        file_bytes.push_back(8'd0);
        if (header_mode != HdrNoSections) begin
          // Every operation once, placed at the top of memory so branches wrap.
          foreach (r_funct_set[k]) begin
            w = $urandom;
            if (r_funct_set[k] == FN_SYSCALL) words.push_back({26'd0, FN_SYSCALL});
            else words.push_back({OP_RTYPE, w[19:0], r_funct_set[k]});
          end
          foreach (i_opcode_set[k]) begin
            w = $urandom;
            words.push_back({i_opcode_set[k], w[25:0]});
          end
          w = $urandom;
          words.push_back({OP_J, 26'h3ffffff});
          words.push_back({OP_JAL, 26'd0});
          words.push_back({OP_RTYPE, 20'hfffff, FN_ADD});
          words.push_back({OP_RTYPE, 20'hfffff, FN_SLL});
          words.push_back({OP_BEQ, 10'h3ff, 16'h8000});
          words.push_back({OP_BNE, 10'd0, 16'h7fff});
          words.push_back({OP_RTYPE, w[19:0], FnUnused});
          put_header(SectText, 32'hffff_fff0, words.size() * 4);
          foreach (words[k]) put_u32(words[k]);
          put_header(SectData, 32'hffff_ffff, 32'd0);
          put_header(SectData, 32'd0, 32'd3);
          file_bytes.push_back(8'h00);
          file_bytes.push_back(8'hff);
          file_bytes.push_back(8'($urandom));
          put_header(SectText, $urandom, 32'd6);
          put_u32(random_word());
          put_u32(random_word());
          put_header(SectText, $urandom, 32'd0);
          sect_count = 5;

          while (file_bytes.size() < 600 && sect_count < 200) begin
            if ($urandom_range(0, 99) < 55) begin
              size = $urandom_range(0, 24);
              put_header(SectText, $urandom, size);
              repeat ((size + 3) / 4) put_u32(random_word());
            end else begin
              size = $urandom_range(0, 12);
              put_header(SectData, $urandom, size);
              repeat (size) file_bytes.push_back(8'($urandom));
            end
            sect_count++;
          end

          end_mode = $urandom_range(0, 3);
          if (end_mode == EndNormal) begin
            if ($urandom_range(0, 1)) begin
              put_header(SectData, $urandom, 32'd0);
              sect_count++;
            end
          end else if (end_mode == EndBadType) begin
            do b = 8'($urandom); while (b == SectText || b == SectData);
            file_bytes.push_back(b);
            sect_count++;
          end else begin
            put_header(SectText, $urandom, 32'd8);
            put_u32(random_word());
            w = $urandom;
            if (end_mode == EndBadOpcode) begin
              do op = 6'($urandom_range(0, 63));
              while (op == OP_RTYPE || op == OP_J || op == OP_JAL ||
                     sb.op_mnemonic(op) != MN_NONE);
              put_u32({op, w[25:0]});
            end else begin
              if (w[25:6] == '0) w[6] = 1'b1;
              put_u32({OP_RTYPE, w[25:6], FN_SYSCALL});
            end
            sect_count++;
          end
          file_bytes[count_pos] = 8'(sect_count);
        end
      end
    end
    // Bytes past the end of the file must be ignored.
    repeat (20) file_bytes.push_back(8'($urandom));
    while (file_bytes.size() < FileBytes) file_bytes.push_back(8'($urandom));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (file_bytes[i]) begin
      case ((i / PhaseBytes) % 4)
        0: begin gap_pct = 0;       stall_pct = 0;       end
        1: begin gap_pct = IdlePct; stall_pct = 0;       end
        2: begin gap_pct = 0;       stall_pct = IdlePct; end
        default: begin gap_pct = BothPct; stall_pct = BothPct; end
      endcase
      send_byte(file_bytes[i]);
    end
    push <= 1'b0;

    while (sb.predicted_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
